### hdl/jsu_pkg.sv
// shared types and constants for the json string unescaper
package jsu_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_DEL       = 8'h7F;

   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // one unit of work for the back end: a finished single result,
   // or a code point that still has to be expanded to utf-8
   typedef struct packed {
      logic        utf8;
      logic [15:0] value;
      kind_type    kind;
   } op_type;

endpackage

### hdl/json_string_unescape_core.sv
// json string unescaper top level: front end, op queue and back end
//
// Bytes of a string body (after the opening quote) go in on the req_ side:
// a byte is taken at a clock edge where req_push is high and req_full low.
// Results come out on the rsp_ side: while rsp_empty is low the oldest
// result is on rsp_out_byte, rsp_kind and rsp_last, and it is taken at an
// edge where rsp_pop is high. rsp_kind is 0 for a data byte, 1 for the
// closing quote and 2 for an error; rsp_last marks the final result of a
// byte. Backslash, 'u' and the first three hex digits give no result.
// One byte is taken per cycle while req_full is low. Results go through
// the op queue and the output register. A \u escape of two or three utf-8
// bytes holds the back end while it puts them out, one per cycle while
// rsp_pop is high; the op queue in between (QUEUE_DEPTH entries) absorbs
// that while the front keeps taking bytes. While rsp_pop stays low the
// output register holds its result, the queue fills and req_full rises;
// nothing is dropped. Reset clears the escape state, the queue and the
// output valid flag; the block takes bytes as soon as reset is released.
module json_string_unescape_core #(
   parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_last
);
   import jsu_pkg::*;

   logic   accept;
   logic   op_valid;
   op_type op;
   logic   q_full, q_empty, q_pop;
   op_type q_head;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_in_byte),
      .op_valid (op_valid),
      .op       (op)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept && op_valid),
      .push_op (op),
      .full    (q_full),
      .pop     (q_pop),
      .head_op (q_head),
      .empty   (q_empty)
   );

   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_op      (q_head),
      .head_empty   (q_empty),
      .head_pop     (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_last     (rsp_last)
   );

`ifndef SYNTH
   // end and error results are always the only result of their byte
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != KIND_DATA) |-> (rsp_last && rsp_out_byte == 8'h00))
      else $error("end or error result not marked last");

   // the back end never pulls from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("op queue popped while empty");

   // output register is empty after reset
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> rsp_empty)
      else $error("result pending right after reset");
`endif

endmodule

### hdl/jsu_front.sv
// front end: escape state machine, maps each raw byte to an op or none
module jsu_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      in_byte,
   output logic            op_valid,
   output jsu_pkg::op_type op
);
   import jsu_pkg::*;

   typedef enum logic [5:0] {
      MODE_NORMAL = 6'b000001,
      MODE_ESCAPE = 6'b000010,
      MODE_HEX0   = 6'b000100,
      MODE_HEX1   = 6'b001000,
      MODE_HEX2   = 6'b010000,
      MODE_HEX3   = 6'b100000
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [11:0] hex_ff, hex_in;
   logic        digit_ok;
   logic [3:0]  digit;

   always_comb begin
      digit_ok = 1'b1;
      digit    = 4'd0;
      case (in_byte) inside
         [8'h30:8'h39]: digit = in_byte[3:0];
         [8'h41:8'h46], [8'h61:8'h66]: digit = in_byte[3:0] + 4'd9;
         default: digit_ok = 1'b0;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      hex_in   = hex_ff;
      op_valid = 1'b0;
      op.utf8  = 1'b0;
      op.value = {8'h00, in_byte};
      op.kind  = KIND_DATA;
      case (mode_ff)
         MODE_ESCAPE: begin
            mode_in  = MODE_NORMAL;
            op_valid = 1'b1;
            case (in_byte)
               "n":  op.value = 16'h000A;
               "r":  op.value = 16'h000D;
               "t":  op.value = 16'h0009;
               "b":  op.value = 16'h0008;
               "f":  op.value = 16'h000C;
               "\"", "\\", "/": op.value = {8'h00, in_byte};
               "u": begin
                  op_valid = 1'b0;
                  mode_in  = MODE_HEX0;
                  hex_in   = '0;
               end
               default: begin
                  op.value = '0;
                  op.kind  = KIND_ERROR;
                  hex_in   = '0;
               end
            endcase
         end
         MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
            if (!digit_ok) begin
               op_valid = 1'b1;
               op.value = '0;
               op.kind  = KIND_ERROR;
               mode_in  = MODE_NORMAL;
               hex_in   = '0;
            end else if (mode_ff == MODE_HEX3) begin
               op_valid = 1'b1;
               op.utf8  = 1'b1;
               op.value = {hex_ff, digit};
               mode_in  = MODE_NORMAL;
               hex_in   = '0;
            end else begin
               hex_in = {hex_ff[7:0], digit};
               case (mode_ff)
                  MODE_HEX0: mode_in = MODE_HEX1;
                  MODE_HEX1: mode_in = MODE_HEX2;
                  default:   mode_in = MODE_HEX3;
               endcase
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            hex_in  = '0;
            if (in_byte == CHAR_BACKSLASH) begin
               mode_in = MODE_ESCAPE;
            end else if (in_byte == CHAR_QUOTE) begin
               op_valid = 1'b1;
               op.value = '0;
               op.kind  = KIND_END;
            end else if (in_byte < CHAR_SPACE || in_byte == CHAR_DEL) begin
               op_valid = 1'b1;
               op.value = '0;
               op.kind  = KIND_ERROR;
            end else begin
               op_valid = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         hex_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hex_ff  <= hex_in;
      end
   end

endmodule

### hdl/jsu_queue.sv
// short op queue between the front and back ends
module jsu_queue #(
   parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  jsu_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output jsu_pkg::op_type head_op,
   output logic            empty
);
   import jsu_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   op_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign head_op = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

### hdl/jsu_back.sv
// back end: expands ops into result bytes and holds the output register
module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  jsu_pkg::op_type    head_op,
   input  logic               head_empty,
   output logic               head_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [7:0]         rsp_out_byte,
   output logic [1:0]         rsp_kind,
   output logic               rsp_last
);
   import jsu_pkg::*;

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   kind_type   kind_ff;
   logic       last_ff, last_in;
   logic       load;
   logic       below_80, below_800;
   logic [15:0] cp;

   assign cp        = head_op.value;
   assign below_80  = (cp[15:7] == '0);
   assign below_800 = (cp[15:11] == '0);

   // pick the utf-8 byte for the current step of a code point
   always_comb begin
      byte_in = cp[7:0];
      last_in = 1'b1;
      if (head_op.utf8) begin
         case (step_ff)
            2'd0: begin
               if (below_80) begin
                  byte_in = cp[7:0];
               end else if (below_800) begin
                  byte_in = UTF8_LEAD2 | {3'b000, cp[10:6]};
                  last_in = 1'b0;
               end else begin
                  byte_in = UTF8_LEAD3 | {4'b0000, cp[15:12]};
                  last_in = 1'b0;
               end
            end
            2'd1: begin
               if (below_800) begin
                  byte_in = UTF8_CONT | {2'b00, cp[5:0]};
               end else begin
                  byte_in = UTF8_CONT | {2'b00, cp[11:6]};
                  last_in = 1'b0;
               end
            end
            default: byte_in = UTF8_CONT | {2'b00, cp[5:0]};
         endcase
      end
   end

   assign load     = !head_empty && (!valid_ff || rsp_pop);
   assign head_pop = load && last_in;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = last_in ? 2'd0 : step_ff + 2'd1;
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         kind_ff <= head_op.kind;
         last_ff <= last_in;
      end
   end

   assign rsp_empty    = !valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_last     = last_ff;

endmodule
